[rtl/sha_pkg.sv]
// SHA-256 package: round constants, initial hash values, command and status types.
// Used by the controller, the datapath and the top level; no dependencies.
package sha_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned Rounds = 64;

  // Initial hash value for word i.
  function automatic logic [31:0] sha_iv(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  // Round constant for round t.
  function automatic logic [31:0] sha_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[t];
  endfunction

  // Byte source for a buffer write.
  typedef enum logic [1:0] {
    SrcData = 2'd0,
    SrcPad  = 2'd1,
    SrcZero = 2'd2,
    SrcLen  = 2'd3
  } byte_src_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       wr_en;       // write one byte at the fill pointer
    byte_src_e  wr_src;
    logic       count_byte;  // count a message byte
    logic       load_win;    // load working vars from the chain
    logic       round_en;    // run one round
    logic       fold;        // add working vars into the chain
    logic       restart;     // reload initial hash, clear fill pointer and byte count
    logic       shift_out;   // rotate the chain by one word toward h0
  } sha_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] round;
  } sha_sts_t;

endpackage

[rtl/sha_datapath.sv]
// SHA-256 datapath: block words in the schedule window, round unit, chain.
// Depends on sha_pkg; driven by sha_ctrl through sha_cmd_t.
module sha_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha_pkg::sha_cmd_t cmd_i,
  input  logic [7:0]        data_byte_i,
  output sha_pkg::sha_sts_t sts_o,
  output logic [31:0]       h0_o
);
  import sha_pkg::*;

  logic [5:0]  fill_q, fill_d;
  logic [60:0] msg_q, msg_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [7:0]  wr_byte;
  logic [63:0] bits;
  logic [2:0]  len_sel;
  logic [31:0] x15, x2, s0, s1, wnew, wcur, t1, t2, ch, maj, e1, a0;

  assign bits    = {msg_q, 3'b000};
  assign len_sel = fill_q[2:0];

  // Byte to write into the block.
  always_comb begin
    case (cmd_i.wr_src)
      SrcData: wr_byte = data_byte_i;
      SrcPad:  wr_byte = 8'h80;
      SrcZero: wr_byte = 8'h00;
      default: wr_byte = bits[8*(7-len_sel) +: 8];
    endcase
  end

  // Fill pointer, byte count and round counter.
  always_comb begin
    fill_d = fill_q;
    msg_d  = msg_q;
    rnd_d  = rnd_q;
    if (cmd_i.wr_en) begin
      fill_d = fill_q + 6'd1;
    end
    if (cmd_i.count_byte) begin
      msg_d = msg_q + 61'd1;
    end
    if (cmd_i.load_win) begin
      rnd_d = '0;
    end else if (cmd_i.round_en) begin
      rnd_d = rnd_q + 6'd1;
    end
    if (cmd_i.restart) begin
      fill_d = '0;
      msg_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      msg_q  <= '0;
      rnd_q  <= '0;
    end else begin
      fill_q <= fill_d;
      msg_q  <= msg_d;
      rnd_q  <= rnd_d;
    end
  end

  // Schedule: the window shifts by one word each round; w_q[0] is this round's word.
  assign x15  = w_q[1];
  assign x2   = w_q[14];
  assign s0   = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
  assign s1   = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
  assign wnew = w_q[0] + s0 + w_q[9] + s1;
  assign wcur = w_q[0];

  // Round function.
  assign e1  = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
             ^ {v_q[4][24:0], v_q[4][31:25]};
  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign a0  = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
             ^ {v_q[0][21:0], v_q[0][31:22]};
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1  = v_q[7] + e1 + ch + sha_k(rnd_q) + wcur;
  assign t2  = a0 + maj;

  // Block bytes land big-endian in the window words; rounds then shift the window.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= wr_byte;
    end else if (cmd_i.load_win) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= h_q[i];
      end
    end else if (cmd_i.round_en) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= wnew;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  // Chaining value: fold, rotate out, reload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= sha_iv(3'(i));
      end
    end else if (cmd_i.restart) begin
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= sha_iv(3'(i));
      end
    end else if (cmd_i.fold) begin
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= h_q[i] + v_q[i];
      end
    end else if (cmd_i.shift_out) begin
      for (int i = 0; i < 7; i++) begin
        h_q[i] <= h_q[i+1];
      end
      h_q[7] <= h_q[0];
    end
  end

  assign h0_o        = h_q[0];
  assign sts_o.fill  = fill_q;
  assign sts_o.round = rnd_q;

endmodule

[rtl/sha_ctrl.sv]
// SHA-256 controller: handshakes, padding sequence, round sequencing, digest output.
// Depends on sha_pkg; commands sha_datapath.
module sha_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              byte_valid_i,
  input  logic              eom_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        word_idx_o,
  input  sha_pkg::sha_sts_t sts_i,
  output sha_pkg::sha_cmd_t cmd_o
);
  import sha_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StLoad  = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StFold  = 3'd3;
  localparam logic [2:0] StPad   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       closing_q, closing_d;  // message end pending
  logic       padded_q, padded_d;    // 0x80 already written
  logic [2:0] widx_q, widx_d;
  logic       acc;

  assign in_ready_o  = (state_q == StIdle);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StOut);
  assign word_idx_o  = widx_q;

  always_comb begin
    state_d   = state_q;
    closing_d = closing_q;
    padded_d  = padded_q;
    widx_d    = widx_q;
    cmd_o     = '0;
    cmd_o.wr_src = SrcData;
    case (state_q)
      StIdle: begin
        if (acc) begin
          if (byte_valid_i) begin
            cmd_o.wr_en      = 1'b1;
            cmd_o.count_byte = 1'b1;
          end
          closing_d = eom_i;
          padded_d  = 1'b0;
          if (byte_valid_i && sts_i.fill == 6'd63) begin
            state_d = StLoad;
          end else if (eom_i) begin
            state_d = StPad;
          end
        end
      end
      // One padding byte a cycle until the block is full.
      StPad: begin
        cmd_o.wr_en = 1'b1;
        if (!padded_q) begin
          cmd_o.wr_src = SrcPad;
          padded_d     = 1'b1;
          // 0x80 landing past byte 55 needs an extra block.
        end else if (sts_i.fill >= 6'd56 && !closing_q) begin
          cmd_o.wr_src = SrcLen;
        end else if (sts_i.fill >= 6'd56 && padded_q && closing_q) begin
          cmd_o.wr_src = SrcLen;
        end else begin
          cmd_o.wr_src = SrcZero;
        end
        if (!padded_q && sts_i.fill > 6'd55) begin
          closing_d = 1'b0;
        end
        if (padded_q && sts_i.fill > 6'd55 && !closing_q) begin
          cmd_o.wr_src = SrcZero;
        end
        if (sts_i.fill == 6'd63) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        cmd_o.load_win = 1'b1;
        state_d        = StRound;
      end
      StRound: begin
        cmd_o.round_en = 1'b1;
        if (sts_i.round == 6'(Rounds - 1)) begin
          state_d = StFold;
        end
      end
      StFold: begin
        cmd_o.fold = 1'b1;
        if (!padded_q) begin
          state_d = closing_q ? StPad : StIdle;
        end else if (!closing_q) begin
          // Overflow block done: now the length block.
          closing_d = 1'b1;
          state_d   = StPad;
        end else begin
          widx_d  = '0;
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          cmd_o.shift_out = 1'b1;
          widx_d          = widx_q + 3'd1;
          if (widx_q == 3'd7) begin
            cmd_o.shift_out = 1'b0;
            cmd_o.restart   = 1'b1;
            closing_d       = 1'b0;
            padded_d        = 1'b0;
            state_d         = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      closing_q <= 1'b0;
      padded_q  <= 1'b0;
      widx_q    <= '0;
    end else begin
      state_q   <= state_d;
      closing_q <= closing_d;
      padded_q  <= padded_d;
      widx_q    <= widx_d;
    end
  end

  // Output only appears after a fold of a padded block.
  a_out_after_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == StFold)
    else $error("digest output without final fold");
  // Input is never taken while rounds run.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRound |-> !in_ready_o)
    else $error("input ready during compression");
  // Word index starts at zero for each digest.
  a_widx_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> widx_q == 3'd0)
    else $error("digest index not reset");

endmodule

[rtl/sha256_message_hasher_top.sv]
// SHA-256 message hasher, top level: stream ports and controller/datapath wiring.
// Depends on sha_pkg, sha_ctrl and sha_datapath.
//
// Input channel s_axis: one beat per message byte (tuser[0] marks a valid byte,
// tlast closes the message). A beat with tlast and no valid byte ends the
// message as it stands, so an empty message is allowed.
// Output channel m_axis: eight beats per message, digest words h0..h7, with
// tlast on h7 and the word index in tuser.
// Flow: byte beats are taken while the controller is idle; the 64th byte of a
// block starts a compression (working-variable load, 64 rounds of the single
// round unit, chain fold). On end of message the padding is written one byte a
// cycle up to the block end, then one or two compressions run, then the eight
// words leave.
// The input is not ready during padding, compression or digest output.
// Reset loads the initial hash values and clears the byte count and fill.
// If the receiver stalls, the current digest word holds until it is taken.
module sha256_message_hasher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);
  import sha_pkg::*;

  sha_cmd_t   cmd;
  sha_sts_t   sts;
  logic [2:0] widx;

  sha_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .byte_valid_i (s_axis_tuser),
    .eom_i        (s_axis_tlast),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .word_idx_o   (widx),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  sha_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .data_byte_i (s_axis_tdata),
    .sts_o       (sts),
    .h0_o        (m_axis_tdata)
  );

  assign m_axis_tuser = widx;
  assign m_axis_tlast = (widx == 3'd7);

endmodule
